FILE: rtl/swlp_pkg.sv
// Shared types and constants for the sliding window latency percentile unit.
package swlp_pkg;

  // Fixed widths of the stream fields and of the configuration port
  localparam int SAMPLE_IO_W = 32;
  localparam int COUNT_IO_W  = 11;
  localparam int REG_W       = 11;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = 1;

  // Register map: index taken from paddr above the byte offset
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [REG_W-1:0]     WINDOW_RESET    = 11'd1000;

  // Percentile ranks: the median is n*50/100, i.e. n >> 1; the tail
  // ranks are tracked as quotient and remainder of n*P/100.
  localparam int                PCT_W      = 8;
  localparam int                REM_W      = 7;
  localparam int                TAIL_COUNT = 2;
  localparam logic [PCT_W-1:0]  PCT_SCALE  = 8'd100;
  localparam logic [PCT_W-1:0]  PCT_TAIL [TAIL_COUNT] = '{8'd95, 8'd99};

  // Result picks: median, p95, p99
  localparam int PICK_COUNT  = 3;
  localparam int PICK_MEDIAN = 0;
  localparam int PICK_P95    = 1;
  localparam int PICK_P99    = 2;

  // Operation broadcast to every cell of the sorted chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

endpackage

FILE: rtl/swlp_in_if.sv
// Input stream channel: one latency sample per transaction.
interface swlp_in_if;
  logic                               valid;
  logic                               ready;
  logic [swlp_pkg::SAMPLE_IO_W-1:0]   latency_sample;

  modport source (output valid, output latency_sample, input ready);
  modport sink   (input valid, input latency_sample, output ready);
endinterface

FILE: rtl/swlp_out_if.sv
// Result stream channel: three percentiles and the fill count per transaction.
interface swlp_out_if;
  logic                               valid;
  logic                               ready;
  logic [swlp_pkg::SAMPLE_IO_W-1:0]   median_latency;
  logic [swlp_pkg::SAMPLE_IO_W-1:0]   p95_value;
  logic [swlp_pkg::SAMPLE_IO_W-1:0]   p99_value;
  logic [swlp_pkg::COUNT_IO_W-1:0]    samples_held;

  modport source (output valid, output median_latency, output p95_value,
                  output p99_value, output samples_held, input ready);
  modport sink   (input valid, input median_latency, input p95_value,
                  input p99_value, input samples_held, output ready);
endinterface

FILE: rtl/sliding_window_latency_percentiles_unit.sv
// Sliding window latency percentile unit: top level.
//
// Usage: every transaction on the samples channel carries one latency sample.
// The unit keeps the most recent window_size samples (register 0, at byte
// address 0 of the APB port, reset value 1000; 0 acts as 1, values above
// MAX_WINDOW act as MAX_WINDOW) in a chain of cells kept in ascending order,
// and answers each sample with one transaction on the results channel: the
// held samples at sorted ranks n/2, n*95/100 and n*99/100, and n itself.
// Samples wider than SAMPLE_BITS saturate to all ones.
//
// Sequence: an accepted sample passes through S_CHECK, S_SELA and S_SELB, where
// the result is loaded, and the next sample is taken only after that. Each
// sample that has to leave the window first adds a pass through S_CHECK and
// S_SETTLE, as the oldest value comes from the window store's registered read
// port. Shrinking the window drops the excess one sample per such pass.
//
// Reset empties the window and restores window_size. The result sits in an
// output register; if the receiver stalls, the unit still accepts and
// processes the next sample and holds in its last step until the result
// register frees up.
module sliding_window_latency_percentiles_unit #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  swlp_in_if.sink                             samples,
  swlp_out_if.source                          results,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swlp_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [swlp_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [swlp_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W = (CNT_W > swlp_pkg::REG_W) ? CNT_W : swlp_pkg::REG_W;
  localparam int IN_W  = swlp_pkg::SAMPLE_IO_W;
  localparam int CIO_W = swlp_pkg::COUNT_IO_W;
  localparam int NT    = swlp_pkg::TAIL_COUNT;
  localparam int RW    = swlp_pkg::REM_W;
  localparam int PW    = swlp_pkg::PCT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SETTLE,
    S_SELA,
    S_SELB
  } state_t;

  state_t state;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [swlp_pkg::REG_W-1:0]     window_size;
  logic [swlp_pkg::REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[swlp_pkg::APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == swlp_pkg::REG_WINDOW_SIZE) ?
                   swlp_pkg::APB_DATA_W'(window_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swlp_pkg::WINDOW_RESET;
    end else if (psel && penable && pwrite && pready &&
                 reg_idx == swlp_pkg::REG_WINDOW_SIZE) begin
      window_size <= pwdata[swlp_pkg::REG_W-1:0];
    end
  end

  // clamp the window to 1..MAX_WINDOW
  logic [CNT_W-1:0] w_eff;

  always_comb begin
    if (window_size == '0) begin
      w_eff = CNT_W'(1);
    end else if (CMP_W'(window_size) > CMP_W'(MAX_WINDOW)) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(window_size);
    end
  end

  // ---------------------------------------------------------------------
  // Input saturation
  // ---------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] sample_sat;
  logic [SAMPLE_BITS-1:0] sample_q;

  if (SAMPLE_BITS >= IN_W) begin : g_sat_wide
    assign sample_sat = SAMPLE_BITS'(samples.latency_sample);
  end else begin : g_sat_narrow
    assign sample_sat = (|samples.latency_sample[IN_W-1:SAMPLE_BITS]) ?
                        '1 : samples.latency_sample[SAMPLE_BITS-1:0];
  end

  // ---------------------------------------------------------------------
  // Window bookkeeping: circular store of arrival order
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0]       fill;
  logic [IDX_W-1:0]       oldest;
  logic [IDX_W-1:0]       oldest_next;
  logic [IDX_W:0]         slot_sum;
  logic [IDX_W-1:0]       slot;
  logic                   evict;
  logic                   ram_we;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  assign evict       = (fill >= w_eff);
  assign oldest_next = (oldest == IDX_W'(MAX_WINDOW - 1)) ? '0 : oldest + 1'b1;
  assign slot_sum    = {1'b0, oldest} + {1'b0, fill[IDX_W-1:0]};
  assign slot        = (slot_sum >= (IDX_W + 1)'(MAX_WINDOW)) ?
                       IDX_W'(slot_sum - (IDX_W + 1)'(MAX_WINDOW)) : IDX_W'(slot_sum);
  assign ram_we      = (state == S_CHECK) && !evict;

  // read port always points at the oldest sample
  swlp_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (sample_q),
    .raddr (oldest),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Sorted chain of cells
  // ---------------------------------------------------------------------
  swlp_pkg::cell_op_t     cell_op;
  logic [SAMPLE_BITS-1:0] cell_key;
  logic [SAMPLE_BITS-1:0] cval [MAX_WINDOW];
  logic                   cvalid [MAX_WINDOW];
  logic                   cgt [MAX_WINDOW];

  always_comb begin
    cell_op = swlp_pkg::OP_HOLD;
    if (state == S_CHECK) begin
      cell_op = evict ? swlp_pkg::OP_REMOVE : swlp_pkg::OP_INSERT;
    end
  end

  // evict by the oldest value, insert the new sample
  assign cell_key = evict ? ram_rdata : sample_q;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] lv;
    logic [SAMPLE_BITS-1:0] rv;
    logic                   lvld;
    logic                   lgt;
    logic                   rvld;

    if (i == 0) begin : g_head
      assign lv   = '0;
      assign lvld = 1'b1;
      assign lgt  = 1'b0;
    end else begin : g_mid_l
      assign lv   = cval[i-1];
      assign lvld = cvalid[i-1];
      assign lgt  = cgt[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_tail
      assign rv   = '0;
      assign rvld = 1'b0;
    end else begin : g_mid_r
      assign rv   = cval[i+1];
      assign rvld = cvalid[i+1];
    end

    swlp_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (cell_op),
      .key         (cell_key),
      .left_value  (lv),
      .left_valid  (lvld),
      .left_gt     (lgt),
      .right_value (rv),
      .right_valid (rvld),
      .value       (cval[i]),
      .valid       (cvalid[i]),
      .gt          (cgt[i])
    );
  end

  // ---------------------------------------------------------------------
  // Rank tracking: floor(n*P/100) kept as quotient and remainder,
  // stepped by one sample at a time
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0] q_tail [NT];
  logic [RW-1:0]    r_tail [NT];
  logic [IDX_W-1:0] q_up [NT];
  logic [RW-1:0]    r_up [NT];
  logic [IDX_W-1:0] q_dn [NT];
  logic [RW-1:0]    r_dn [NT];
  logic [PW-1:0]    r_add [NT];

  always_comb begin
    for (int t = 0; t < NT; t++) begin
      r_add[t] = PW'(r_tail[t]) + swlp_pkg::PCT_TAIL[t];
      if (r_add[t] >= swlp_pkg::PCT_SCALE) begin
        r_up[t] = RW'(r_add[t] - swlp_pkg::PCT_SCALE);
        q_up[t] = q_tail[t] + 1'b1;
      end else begin
        r_up[t] = RW'(r_add[t]);
        q_up[t] = q_tail[t];
      end
      if (PW'(r_tail[t]) >= swlp_pkg::PCT_TAIL[t]) begin
        r_dn[t] = RW'(PW'(r_tail[t]) - swlp_pkg::PCT_TAIL[t]);
        q_dn[t] = q_tail[t];
      end else begin
        r_dn[t] = RW'(PW'(r_tail[t]) + swlp_pkg::PCT_SCALE - swlp_pkg::PCT_TAIL[t]);
        q_dn[t] = q_tail[t] - 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Rank selection
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0]       rank [swlp_pkg::PICK_COUNT];
  logic [SAMPLE_BITS-1:0] picked [swlp_pkg::PICK_COUNT];
  logic [IN_W-1:0]        pick_io [swlp_pkg::PICK_COUNT];

  assign rank[swlp_pkg::PICK_MEDIAN] = IDX_W'(fill >> 1);
  assign rank[swlp_pkg::PICK_P95]    = q_tail[0];
  assign rank[swlp_pkg::PICK_P99]    = q_tail[1];

  swlp_select #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_select (
    .clk    (clk),
    .values (cval),
    .rank   (rank),
    .picked (picked)
  );

  for (genvar p = 0; p < swlp_pkg::PICK_COUNT; p++) begin : g_pick
    if (SAMPLE_BITS >= IN_W) begin : g_trunc
      assign pick_io[p] = picked[p][IN_W-1:0];
    end else begin : g_ext
      assign pick_io[p] = IN_W'(picked[p]);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer and result register
  // ---------------------------------------------------------------------
  logic              res_valid;
  logic              res_load;
  logic [IN_W-1:0]   res_median;
  logic [IN_W-1:0]   res_p95;
  logic [IN_W-1:0]   res_p99;
  logic [CIO_W-1:0]  res_held;

  // load a new result when the register is empty or being emptied this cycle
  assign res_load = (state == S_SELB) && (!res_valid || results.ready);

  assign samples.ready          = (state == S_IDLE);
  assign results.valid          = res_valid;
  assign results.median_latency = res_median;
  assign results.p95_value      = res_p95;
  assign results.p99_value      = res_p99;
  assign results.samples_held   = res_held;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      oldest    <= '0;
      res_valid <= 1'b0;
      for (int t = 0; t < NT; t++) begin
        q_tail[t] <= '0;
        r_tail[t] <= '0;
      end
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            sample_q <= sample_sat;
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (evict) begin
            // drop the oldest sample, then wait for the store to read the next
            oldest <= oldest_next;
            fill   <= fill - 1'b1;
            for (int t = 0; t < NT; t++) begin
              q_tail[t] <= q_dn[t];
              r_tail[t] <= r_dn[t];
            end
            state <= S_SETTLE;
          end else begin
            fill <= fill + 1'b1;
            for (int t = 0; t < NT; t++) begin
              q_tail[t] <= q_up[t];
              r_tail[t] <= r_up[t];
            end
            state <= S_SELA;
          end
        end
        S_SETTLE: begin
          state <= S_CHECK;
        end
        S_SELA: begin
          state <= S_SELB;
        end
        S_SELB: begin
          // hold until the result register is free
          if (res_load) begin
            res_median <= pick_io[swlp_pkg::PICK_MEDIAN];
            res_p95    <= pick_io[swlp_pkg::PICK_P95];
            res_p99    <= pick_io[swlp_pkg::PICK_P99];
            res_held   <= CIO_W'(fill);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/swlp_ram.sv
// Generic single write port, single read port RAM with registered read data.
module swlp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/swlp_cell.sv
// One cell of the sorted sample chain: holds one sample and a valid flag.
module swlp_cell #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  swlp_pkg::cell_op_t     op,
  input  logic [SAMPLE_BITS-1:0] key,
  input  logic [SAMPLE_BITS-1:0] left_value,
  input  logic                   left_valid,
  input  logic                   left_gt,
  input  logic [SAMPLE_BITS-1:0] right_value,
  input  logic                   right_valid,
  output logic [SAMPLE_BITS-1:0] value,
  output logic                   valid,
  output logic                   gt
);

  logic ge;

  assign gt = valid && (value > key);
  assign ge = valid && (value >= key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (op)
        swlp_pkg::OP_INSERT: begin
          // open a slot after all entries not above the key
          if (gt || (!valid && left_valid)) begin
            value <= left_gt ? left_value : key;
            valid <= 1'b1;
          end
        end
        swlp_pkg::OP_REMOVE: begin
          // close the gap left by the first entry equal to the key
          if (ge) begin
            value <= right_value;
            valid <= right_valid;
          end
        end
        swlp_pkg::OP_HOLD: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/swlp_select.sv
// Two-stage rank selector: picks chain entries at three ranks.
module swlp_select #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic [SAMPLE_BITS-1:0]        values [MAX_WINDOW],
  input  logic [$clog2(MAX_WINDOW)-1:0] rank [swlp_pkg::PICK_COUNT],
  output logic [SAMPLE_BITS-1:0]        picked [swlp_pkg::PICK_COUNT]
);

  localparam int IDX_W  = $clog2(MAX_WINDOW);
  localparam int GRP_W  = (IDX_W > 5) ? 5 : IDX_W;
  localparam int GRP    = 2 ** GRP_W;
  localparam int NGRP   = 2 ** (IDX_W - GRP_W);
  localparam int PAD    = 2 ** IDX_W;
  localparam logic [IDX_W-1:0] LO_MASK = IDX_W'(GRP - 1);

  logic [SAMPLE_BITS-1:0] vals_pad [PAD];
  logic [SAMPLE_BITS-1:0] grp_next [swlp_pkg::PICK_COUNT][NGRP];
  logic [SAMPLE_BITS-1:0] grp      [swlp_pkg::PICK_COUNT][NGRP];

  for (genvar e = 0; e < PAD; e++) begin : g_pad
    if (e < MAX_WINDOW) begin : g_real
      assign vals_pad[e] = values[e];
    end else begin : g_fill
      assign vals_pad[e] = '0;
    end
  end

  // stage one: pick within each group by the low rank bits
  always_comb begin
    for (int p = 0; p < swlp_pkg::PICK_COUNT; p++) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_next[p][g] = '0;
        for (int j = 0; j < GRP; j++) begin
          if ((rank[p] & LO_MASK) == IDX_W'(j)) begin
            grp_next[p][g] = grp_next[p][g] | vals_pad[g * GRP + j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp <= grp_next;
  end

  // stage two: pick the group by the high rank bits
  always_comb begin
    for (int p = 0; p < swlp_pkg::PICK_COUNT; p++) begin
      picked[p] = '0;
      for (int g = 0; g < NGRP; g++) begin
        if ((rank[p] >> GRP_W) == IDX_W'(g)) begin
          picked[p] = picked[p] | grp[p][g];
        end
      end
    end
  end

endmodule

FILE: test/tb_sliding_window_latency_percentiles_unit.sv
// Self-checking testbench for the sliding window latency percentile unit.
module tb_sliding_window_latency_percentiles_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WINDOW     = 1024;
  localparam int MEDIAN_PCT     = 50;
  localparam int P95_PCT        = 95;
  localparam int P99_PCT        = 99;
  localparam int PCT_DIV        = 100;
  localparam int MAX_REPORTS    = 10;
  localparam int LONG_STALL     = 300;
  localparam int STALL_AT_ITEM  = 400;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int DRAIN_CYCLES   = 20;

  // Register 0 lies at byte 0; index 1 is not mapped, writes to it are dropped.
  localparam logic [swlp_pkg::APB_ADDR_W-1:0] ADDR_WINDOW   =
    {swlp_pkg::REG_WINDOW_SIZE, 2'b00};
  localparam logic [swlp_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED =
    {~swlp_pkg::REG_WINDOW_SIZE, 2'b00};

  typedef logic [swlp_pkg::SAMPLE_IO_W-1:0] sample_t;

  typedef struct packed {
    sample_t                         median_latency;
    sample_t                         p95_value;
    sample_t                         p99_value;
    logic [swlp_pkg::COUNT_IO_W-1:0] samples_held;
  } pick_t;

  // Directed samples: extremes, single bits, patterns, duplicates, runs.
  localparam sample_t EDGE_SAMPLES [25] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE, 32'h8000_0000,
    32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0005, 32'h0000_0005,
    32'h0000_0005, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000, 32'h0000_FFFF,
    32'h0000_0064, 32'h0000_0063, 32'h0000_0062, 32'h0000_0061, 32'h0000_0060,
    32'h1234_5678, 32'h8765_4321, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 32'hFFFF_FFFF
  };

  // Window model plus the queue of percentile picks still owed by the unit.
  class window_ranker;
    sample_t                    held[$];
    pick_t                      expected_picks[$];
    logic [swlp_pkg::REG_W-1:0] window_size;
    int                         errors;
    int                         reported;

    function new();
      window_size = swlp_pkg::WINDOW_RESET;
      errors      = 0;
      reported    = 0;
    endfunction

    function void write_register(logic [swlp_pkg::APB_ADDR_W-1:0] addr,
                                 logic [swlp_pkg::APB_DATA_W-1:0] data);
      if (addr[swlp_pkg::APB_ADDR_W-1 -: swlp_pkg::REG_IDX_W] == swlp_pkg::REG_WINDOW_SIZE)
        window_size = data[swlp_pkg::REG_W-1:0];
    endfunction

    function void note_sample(sample_t sample);
      int unsigned limit;
      int unsigned n;
      sample_t     ranked[$];
      pick_t       p;
      limit = (window_size == 0) ? 1 :
              (window_size > MAX_WINDOW) ? MAX_WINDOW : int'(window_size);
      while (held.size() >= limit)
        held.delete(0);
      held = {held, sample};
      ranked = held;
      ranked.sort();
      n = held.size();
      p.median_latency = ranked[n * MEDIAN_PCT / PCT_DIV];
      p.p95_value      = ranked[n * P95_PCT / PCT_DIV];
      p.p99_value      = ranked[n * P99_PCT / PCT_DIV];
      p.samples_held   = n[swlp_pkg::COUNT_IO_W-1:0];
      expected_picks = {expected_picks, p};
    endfunction

    function void check_result(pick_t got);
      pick_t want;
      if (expected_picks.size() == 0) begin
        errors++;
        if (reported < MAX_REPORTS) begin
          reported++;
          $display("[%0t] unexpected result: median %h p95 %h p99 %h held %0d",
                   $realtime, got.median_latency, got.p95_value, got.p99_value,
                   got.samples_held);
        end
        return;
      end
      want = expected_picks[0];
      expected_picks.delete(0);
      if (got.median_latency !== want.median_latency || got.p95_value !== want.p95_value ||
          got.p99_value !== want.p99_value || got.samples_held !== want.samples_held) begin
        errors++;
        if (reported < MAX_REPORTS) begin
          reported++;
          $display("[%0t] mismatch: expected median %h p95 %h p99 %h held %0d", $realtime,
                   want.median_latency, want.p95_value, want.p99_value, want.samples_held);
          $display("             actual   median %h p95 %h p99 %h held %0d",
                   got.median_latency, got.p95_value, got.p99_value, got.samples_held);
        end
      end
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [swlp_pkg::APB_ADDR_W-1:0] paddr;
  logic [swlp_pkg::APB_DATA_W-1:0] pwdata;
  logic [swlp_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  swlp_in_if  samples_ch();
  swlp_out_if results_ch();

  window_ranker ranker = new();
  int           samples_in = 0;
  bit           calm = 0;
  bit           long_stall_done = 0;
  int           idle_cycles = 0;

  sliding_window_latency_percentiles_unit dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Drive every input to a known value at time zero, with reset asserted.
  initial begin
    rst                       = 1'b1;
    psel                      = 1'b0;
    penable                   = 1'b0;
    pwrite                    = 1'b0;
    paddr                     = '0;
    pwdata                    = '0;
    samples_ch.valid          = 1'b0;
    samples_ch.latency_sample = '0;
    results_ch.ready          = 1'b0;
  end

  // Observe every handshake at the rising edge, where all inputs are stable.
  always @(posedge clk) begin : observe
    pick_t got;
    if (!rst) begin
      if (samples_ch.valid && samples_ch.ready) begin
        ranker.note_sample(samples_ch.latency_sample);
        samples_in++;
      end
      if (results_ch.valid && results_ch.ready) begin
        got.median_latency = results_ch.median_latency;
        got.p95_value      = results_ch.p95_value;
        got.p99_value      = results_ch.p99_value;
        got.samples_held   = results_ch.samples_held;
        ranker.check_result(got);
      end
      if (psel && penable && pwrite && pready)
        ranker.write_register(paddr, pwdata);
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[%0t] no transaction for %0d cycles", $realtime, WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Result receiver: random ready bursts, one long hold-off once the window is
  // filling, and a steady ready once the run turns calm.
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (calm) begin
        results_ch.ready = 1'b1;
        @(negedge clk);
      end else if (!long_stall_done && samples_in >= STALL_AT_ITEM) begin
        // Hold off long enough for the unit to back up into its input.
        long_stall_done  = 1'b1;
        results_ch.ready = 1'b0;
        for (int c = 0; c < LONG_STALL; c++) @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        results_ch.ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        results_ch.ready = 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  end

  // Offer one sample and hold it until the unit takes it; return at a falling
  // edge with valid still high so back-to-back samples need no re-raise.
  task automatic send_sample(sample_t value);
    samples_ch.valid          = 1'b1;
    samples_ch.latency_sample = value;
    do @(posedge clk); while (!samples_ch.ready);
    @(negedge clk);
  endtask

  // Mix full-range words with clustered values so ranks see duplicates.
  function automatic sample_t random_sample();
    unique case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 15);
      1:       return $urandom_range(0, 1000);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      3:       return sample_t'(1) << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Drop valid and wait until every owed result has been taken.
  task automatic drain();
    samples_ch.valid = 1'b0;
    while (ranker.pending() != 0) @(negedge clk);
  endtask

  task automatic apb_write(logic [swlp_pkg::APB_ADDR_W-1:0] addr,
                           logic [swlp_pkg::APB_DATA_W-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Random samples; some stretches are gap-free, others get idle bursts.
  task automatic random_items(int count);
    bit gappy;
    gappy = !calm && ($urandom_range(0, 3) != 0);
    for (int i = 0; i < count; i++) begin
      if (gappy && $urandom_range(0, 4) == 0) begin
        samples_ch.valid = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      send_sample(random_sample());
    end
  endtask

  // Reconfigure only when idle, then stream samples at the new window size.
  task automatic run_phase(logic [swlp_pkg::APB_DATA_W-1:0] window_word, int count);
    drain();
    apb_write(ADDR_WINDOW, window_word);
    random_items(count);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed samples at the reset window size.
    foreach (EDGE_SAMPLES[i])
      send_sample(EDGE_SAMPLES[i]);

    // Single-entry window, then zero, which must act as a single entry.
    run_phase(1, 6);
    run_phase(0, 6);

    // Write to the unmapped register: the window must stay at one entry.
    drain();
    apb_write(ADDR_UNMAPPED, 5);
    random_items(6);

    run_phase(2, 20);
    run_phase(5, 60);
    run_phase(100, 150);

    // Shrink while full: the excess leaves on the next sample.
    run_phase(7, 40);

    // Oversized value, clamped to the maximum window.
    run_phase(2047, 60);

    // Fill the maximum window; pause once mid-way until all results are in.
    run_phase(MAX_WINDOW, 500);
    drain();
    random_items(580);

    // Last part: no idling, shrink from a full window, junk in the upper bits.
    calm = 1'b1;
    run_phase(32'hA5A5_0003, 60);

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (ranker.pending() != 0)
      $display("[%0t] %0d results never arrived", $realtime, ranker.pending());
    if (ranker.errors == 0 && ranker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/swlp_pkg.sv
rtl/swlp_in_if.sv
rtl/swlp_out_if.sv
rtl/swlp_ram.sv
rtl/swlp_cell.sv
rtl/swlp_select.sv
rtl/sliding_window_latency_percentiles_unit.sv
test/tb_sliding_window_latency_percentiles_unit.sv
